@@ hdl/uapfr_pkg.sv @@
// Package for the audio ring core: constants, control/status structs, PCM-to-float function.
// No dependencies.
`default_nettype none
package uapfr_pkg;
    localparam int RING_SAMPLES = 16384;
    localparam int MAX_CHANNELS = 32;
    localparam int RING_AW = $clog2(RING_SAMPLES);
    localparam int FILL_W = RING_AW + 1;
    localparam int CH_W = $clog2(MAX_CHANNELS);
    localparam int CNT_W = CH_W + 1;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_PEND = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_STOP = 2'd3;

    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_STOP = 2'd2;

    localparam logic [1:0] CFG_CHANNELS = 2'd0;
    localparam logic [1:0] CFG_BYTES = 2'd1;
    localparam logic [1:0] CFG_FLOAT = 2'd2;

    // Commands from controller to datapath.
    typedef struct packed {
        logic take;        // register the input item
        logic conv;        // convert the held sample into the pending buffer
        logic commit_step; // write one pending sample into the ring
        logic commit_end;  // finish a frame commit
        logic pkt_end;     // packet end
        logic stop;
        logic rd_start;    // issue first ring read
        logic rd_step;     // current result taken, advance read
        logic rd_end;      // pop the frame
    } uapfr_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic stopped;
        logic frame_full;   // pending frame complete after conversion
        logic commit_last;  // commit counter at last sample
        logic can_read;     // fill >= channel count
        logic rd_last;      // current read is last channel
    } uapfr_sts_t;

    // Signed PCM of given byte count to float32, exact up to 3 bytes (value fits in 24 bits);
    // rounding to nearest even only for 4 byte containers.
    function automatic logic [31:0] pcm_to_float(input logic [31:0] w, input logic [2:0] nb);
        logic [31:0] v;
        logic        s;
        logic [31:0] mag;
        logic [5:0]  lz;
        logic [31:0] norm;
        logic [23:0] man;
        logic        g, st;
        logic [24:0] rm;
        logic [7:0]  ex;
        logic [7:0]  bits;
        begin
            case (nb)
                3'd2: v = {w[15:0], 16'd0};
                3'd3: v = {w[23:0], 8'd0};
                3'd4: v = w;
                default: v = {w[7:0], 24'd0};
            endcase
            bits = 8'd32;
            s = v[31];
            mag = s ? (~v + 32'd1) : v;
            lz = 6'd32;
            for (int i = 0; i < 32; i++) begin
                if (mag[i]) lz = 6'(31 - i);
            end
            norm = mag << lz;
            man = norm[31:8];
            g = norm[7];
            st = |norm[6:0];
            rm = {1'b0, man} + 25'(g & (st | man[0]));
            // value = mag*2^-31; msb at 2^-(lz)
            ex = 8'd127 - 8'(lz);
            if (rm[24]) begin
                ex = ex + 8'd1;
                rm = rm >> 1;
            end
            if (mag == 32'd0) pcm_to_float = 32'd0;
            else pcm_to_float = {s, ex, rm[22:0]};
            if (bits == 8'd0) pcm_to_float = 32'd0;
        end
    endfunction
endpackage
`default_nettype wire

@@ hdl/uapfr_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module uapfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hdl/uapfr_ctrl.sv @@
// Controller state machine of the audio ring core.
// Depends on uapfr_pkg.
`default_nettype none
module uapfr_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire uapfr_pkg::uapfr_sts_t sts,
    output uapfr_pkg::uapfr_cmd_t     cmd
);
    import uapfr_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0, S_DEC = 3'd1, S_COMMIT = 3'd2,
                           S_RWAIT = 3'd3, S_OUT = 3'd4, S_EMPTY = 3'd5;
    logic [2:0] state_reg, state_next;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        s_tready = (state_reg == S_IDLE);
        m_tvalid = (state_reg == S_OUT) || (state_reg == S_EMPTY);
        case (state_reg)
            S_IDLE: if (s_tvalid) begin
                cmd.take = 1'b1;
                state_next = S_DEC;
            end
            S_DEC: begin
                state_next = S_IDLE;
                case (sts.mode)
                    MODE_WRITE: if (!sts.stopped) begin
                        cmd.conv = 1'b1;
                        if (sts.frame_full) state_next = S_COMMIT;
                    end
                    MODE_PEND: if (!sts.stopped) cmd.pkt_end = 1'b1;
                    MODE_STOP: cmd.stop = 1'b1;
                    default: begin
                        if (sts.can_read) begin
                            cmd.rd_start = 1'b1;
                            state_next = S_RWAIT;
                        end else state_next = S_EMPTY;
                    end
                endcase
            end
            S_COMMIT: begin
                cmd.commit_step = 1'b1;
                if (sts.commit_last) begin
                    cmd.commit_end = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RWAIT: state_next = S_OUT;
            S_OUT: if (m_tready) begin
                if (sts.rd_last) begin
                    cmd.rd_end = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    cmd.rd_step = 1'b1;
                    state_next = S_RWAIT;
                end
            end
            S_EMPTY: if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end
endmodule
`default_nettype wire

@@ hdl/uapfr_dp.sv @@
// Datapath of the audio ring core: sample conversion, pending frame, ring, counters.
// Depends on uapfr_pkg and uapfr_ram.
`default_nettype none
module uapfr_dp (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [5:0]            cfg_data,
    input  wire logic [1:0]            in_mode,
    input  wire logic [31:0]           in_word,
    input  wire logic [62:0]           in_ts,
    input  wire uapfr_pkg::uapfr_cmd_t cmd,
    output uapfr_pkg::uapfr_sts_t      sts,
    output logic [1:0]                 o_status,
    output logic [31:0]                o_value,
    output logic [4:0]                 o_channel,
    output logic                       o_last,
    output logic [62:0]                o_oldest,
    output logic [62:0]                o_anc_frame,
    output logic [62:0]                o_anchor_time,
    output logic [62:0]                o_dropped
);
    import uapfr_pkg::*;
    logic [5:0]  chan_reg;
    logic [2:0]  bytes_reg;
    logic        float_reg;
    logic [1:0]  mode_reg;
    logic [31:0] word_reg;
    logic [62:0] ts_reg;
    logic [31:0] pend_reg [MAX_CHANNELS];
    logic [RING_AW-1:0] head_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [CNT_W-1:0]   pos_reg, k_reg;
    logic [62:0] headfr_reg, written_reg, afr_reg, atm_reg, ovf_reg;
    logic        stopped_reg, pkt_reg;
    logic [CNT_W-1:0] cc;
    logic [2:0]  nb;
    logic [31:0] conv;
    logic [CNT_W-1:0] pos_inc;
    logic        need_drop;
    logic [FILL_W-1:0] drop_n;
    logic [31:0] rdata;
    logic [RING_AW-1:0] raddr, waddr;

    always_comb begin
        if (chan_reg == 6'd0) cc = CNT_W'(1);
        else if (chan_reg > 6'(MAX_CHANNELS)) cc = CNT_W'(MAX_CHANNELS);
        else cc = CNT_W'(chan_reg);
        if (bytes_reg == 3'd0) nb = 3'd1;
        else if (bytes_reg > 3'd4) nb = 3'd4;
        else nb = bytes_reg;
        if (float_reg) conv = (word_reg[30:23] == 8'hFF) ? 32'd0 : word_reg;
        else conv = pcm_to_float(word_reg, nb);
        pos_inc = pos_reg + CNT_W'(1);
        need_drop = (32'(fill_reg) + 32'(cc)) > 32'(RING_SAMPLES);
        drop_n = (fill_reg < FILL_W'(cc)) ? fill_reg : FILL_W'(cc);
        waddr = head_reg + RING_AW'(fill_reg) + RING_AW'(k_reg);
        raddr = head_reg + RING_AW'(k_reg);
        sts.mode = mode_reg;
        sts.stopped = stopped_reg;
        sts.frame_full = pos_inc >= cc;
        sts.commit_last = (k_reg + CNT_W'(1)) == cc;
        sts.can_read = (fill_reg != '0) && (fill_reg >= FILL_W'(cc));
        sts.rd_last = (k_reg + CNT_W'(1)) == cc;
    end

    uapfr_ram #(.WIDTH(32), .DEPTH(RING_SAMPLES)) u_ring (
        .aclk(aclk), .we(cmd.commit_step), .waddr(waddr),
        .wdata(pend_reg[k_reg[CH_W-1:0]]), .raddr(raddr), .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            mode_reg <= in_mode;
            word_reg <= in_word;
            ts_reg <= in_ts;
        end
        if (cmd.conv && pos_reg < CNT_W'(MAX_CHANNELS)) pend_reg[pos_reg[CH_W-1:0]] <= conv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg <= 6'd2; bytes_reg <= 3'd2; float_reg <= 1'b0;
            head_reg <= '0; fill_reg <= '0; pos_reg <= '0; k_reg <= '0;
            headfr_reg <= '0; written_reg <= '0; afr_reg <= '0; atm_reg <= '0;
            ovf_reg <= '0; stopped_reg <= 1'b0; pkt_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CHANNELS: chan_reg <= cfg_data;
                    CFG_BYTES: bytes_reg <= cfg_data[2:0];
                    CFG_FLOAT: float_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.conv) begin
                if (pos_inc >= cc) begin
                    pos_reg <= '0;
                    k_reg <= '0;
                    // Drop is decided before the frame is written.
                    if (need_drop) begin
                        head_reg <= head_reg + RING_AW'(drop_n);
                        fill_reg <= fill_reg - drop_n;
                        headfr_reg <= headfr_reg + 63'd1;
                        ovf_reg <= ovf_reg + 63'd1;
                    end
                end else pos_reg <= pos_inc;
            end
            // The last copy cycle rewinds the sample counter for the next use.
            if (cmd.commit_step) k_reg <= cmd.commit_end ? '0 : k_reg + CNT_W'(1);
            if (cmd.commit_end) begin
                fill_reg <= fill_reg + FILL_W'(cc);
                written_reg <= written_reg + 63'd1;
                pkt_reg <= 1'b1;
            end
            if (cmd.pkt_end) begin
                pos_reg <= '0;
                if (pkt_reg) begin
                    afr_reg <= written_reg;
                    atm_reg <= ts_reg;
                end
                pkt_reg <= 1'b0;
            end
            if (cmd.stop) stopped_reg <= 1'b1;
            if (cmd.rd_start) k_reg <= '0;
            if (cmd.rd_step) k_reg <= k_reg + CNT_W'(1);
            if (cmd.rd_end) begin
                k_reg <= '0;
                head_reg <= head_reg + RING_AW'(cc);
                fill_reg <= fill_reg - FILL_W'(cc);
                headfr_reg <= headfr_reg + 63'd1;
            end
        end
    end

    always_comb begin
        if (sts.can_read && mode_reg == MODE_READ) begin
            o_status = ST_DATA;
            o_value = rdata;
            o_channel = k_reg[CH_W-1:0];
            o_last = sts.rd_last;
            o_oldest = headfr_reg;
            o_anc_frame = afr_reg;
            o_anchor_time = atm_reg;
            o_dropped = ovf_reg;
        end else begin
            o_status = (fill_reg == '0 && stopped_reg) ? ST_STOP : ST_EMPTY;
            o_value = '0; o_channel = '0; o_last = 1'b1;
            o_oldest = '0; o_anc_frame = '0; o_anchor_time = '0; o_dropped = '0;
        end
    end
endmodule
`default_nettype wire

@@ hdl/usb_audio_pcm_float_ring_core.sv @@
// Top level of the USB audio PCM/float ring core.
// An item is accepted in S_IDLE and decoded in S_DEC; a write that completes a frame then
// copies the pending frame into the ring in S_COMMIT, sample by sample.
// An empty read shows its result in S_EMPTY, the state after S_DEC; a data read passes
// S_RWAIT and S_OUT for each result. A new item is taken only once the last one is done.
// Reset (aresetn, synchronous, low) empties the ring, clears all counters and loads the defaults.
`default_nettype none
module usb_audio_pcm_float_ring_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [5:0]   cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [1:0]   s_tuser,  // mode
    input  wire logic [95:0]  s_tdata,  // sample_word[31:0], timestamp_ns[94:32]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [1:0]        m_tuser,  // status
    output logic [295:0]      m_tdata,  // sample_value, channel_index, oldest_frame,
                                        // anchor frame, anchor_time, dropped_frames
    output logic              m_tlast
);
    import uapfr_pkg::*;
    uapfr_cmd_t cmd;
    uapfr_sts_t sts;
    logic [31:0] val;
    logic [4:0]  ch;
    logic [62:0] old, afr, atm, drp;

    // The controller sequences each item; the datapath holds the ring, configuration and counters.
    uapfr_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .sts(sts), .cmd(cmd)
    );

    uapfr_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_mode(s_tuser), .in_word(s_tdata[31:0]),
        .in_ts(s_tdata[94:32]), .cmd(cmd), .sts(sts), .o_status(m_tuser), .o_value(val),
        .o_channel(ch), .o_last(m_tlast), .o_oldest(old), .o_anc_frame(afr),
        .o_anchor_time(atm), .o_dropped(drp)
    );

    // Result fields packed from the lowest bit up, zero padded to whole bytes.
    assign m_tdata = {7'd0, drp, atm, afr, old, ch, val};
endmodule
`default_nettype wire

@@ hdl/uapfr_checker.sv @@
// Port-level checker for the audio ring core, bound to the top level.
// Depends on uapfr_pkg and the top level's ports.
`default_nettype none
module uapfr_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [1:0]   m_tuser,
    input wire logic [295:0] m_tdata,
    input wire logic         m_tlast
);
    import uapfr_pkg::*;
    // The core never takes an item while a result waits.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input taken during output");
    // A non-data result is always the last of its item.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_DATA |-> m_tlast) else $error("status without last");
    // Status never holds the unused code.
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_STOP) else $error("bad status");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast)) else $error("output dropped");
endmodule

bind usb_audio_pcm_float_ring_core uapfr_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .m_tlast(m_tlast)
);
`default_nettype wire
